@@ rtl/bdc_pkg.sv @@
// shared types, codes and sizes of the block device command port
// no dependencies; used by every design module of the block by scoped names, not by bdc_checker

package bdc_pkg;

  // command buffer sizing
  localparam int unsigned BUFFER_DEPTH = 16;
  localparam int unsigned FILL_W       = $clog2(BUFFER_DEPTH + 1);
  // only the first bytes of a command carry meaning
  localparam int unsigned CMD_LEN      = 7;

  // bus access kind
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // register offsets within the card window
  localparam logic [3:0] OFF_CLEAR   = 4'd0;
  localparam logic [3:0] OFF_APPEND  = 4'd1;
  localparam logic [3:0] OFF_EXEC    = 4'd2;
  localparam logic [3:0] OFF_ERROR   = 4'd3;
  localparam logic [3:0] OFF_STAT_LO = 4'd4;
  localparam logic [3:0] OFF_STAT_HI = 4'd5;

  // read value of unused offsets
  localparam logic [7:0] RD_UNUSED = 8'hE0;

  // command byte positions
  localparam int unsigned BYTE_VERSION = 0;
  localparam int unsigned BYTE_CMD     = 1;
  localparam int unsigned BYTE_DEV     = 2;
  localparam int unsigned BYTE_BLK_LO  = 3;
  localparam int unsigned BYTE_BLK_HI  = 4;
  localparam int unsigned BYTE_ADR_LO  = 5;
  localparam int unsigned BYTE_ADR_HI  = 6;

  localparam logic [7:0] CMD_VERSION = 8'h01;

  // command codes
  localparam logic [7:0] CMD_STATUS = 8'h00;
  localparam logic [7:0] CMD_READ   = 8'h01;
  localparam logic [7:0] CMD_WRITE  = 8'h02;
  localparam logic [7:0] CMD_FORMAT = 8'h03;

  // configuration register indexes
  localparam logic [2:0] CFG_SLOT      = 3'd0;
  localparam logic [2:0] CFG_D0_MOUNT  = 3'd1;
  localparam logic [2:0] CFG_D1_MOUNT  = 3'd2;
  localparam logic [2:0] CFG_D0_PROT   = 3'd3;
  localparam logic [2:0] CFG_D1_PROT   = 3'd4;
  localparam logic [2:0] CFG_D0_BLOCKS = 3'd5;
  localparam logic [2:0] CFG_D1_BLOCKS = 3'd6;

  // error codes
  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_FORMAT  = 3'd1,
    ERR_IO      = 3'd2,
    ERR_OFFLINE = 3'd3,
    ERR_PROTECT = 3'd4,
    ERR_NODEV   = 3'd5
  } err_e;

  // one bus access
  typedef struct packed {
    op_e        op;
    logic [3:0] offset;
    logic [7:0] wdata;
  } req_t;

  // buffer update from the request decode
  typedef struct packed {
    logic       clear;
    logic       append;
    logic [7:0] data;
  } buf_ctrl_t;

  // buffer contents seen by execute
  typedef struct packed {
    logic [CMD_LEN-1:0][7:0] bytes;
    logic [7:0]              xsum;
  } cmd_view_t;

  // one result item
  typedef struct packed {
    logic [7:0]  rdata;
    logic        xfer_valid;
    logic        xfer_is_write;
    logic        xfer_drive;
    logic [15:0] xfer_block;
    logic [15:0] xfer_mem_addr;
  } result_t;

endpackage

@@ rtl/bdc_cmdbuf.sv @@
// command byte buffer with fill count and running checksum
// depends on bdc_pkg

module bdc_cmdbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdc_pkg::buf_ctrl_t    ctrl_i,
  output bdc_pkg::cmd_view_t    view_o
);

  logic [bdc_pkg::FILL_W-1:0]              fill_q, fill_d;
  logic [7:0]                              xsum_q, xsum_d;
  logic [bdc_pkg::CMD_LEN-1:0][7:0]        bytes_q;
  logic                                    room;

  assign room = fill_q < bdc_pkg::FILL_W'(bdc_pkg::BUFFER_DEPTH);

  // fill count and checksum next state
  always_comb begin
    fill_d = fill_q;
    xsum_d = xsum_q;
    if (ctrl_i.clear) begin
      fill_d = '0;
      xsum_d = '0;
    end else if (ctrl_i.append && room) begin
      fill_d = fill_q + bdc_pkg::FILL_W'(1);
      xsum_d = xsum_q ^ ctrl_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      xsum_q <= '0;
    end else begin
      fill_q <= fill_d;
      xsum_q <= xsum_d;
    end
  end

  // byte store; bytes past the command layout are never read, so not kept
  for (genvar i = 0; i < bdc_pkg::CMD_LEN; i++) begin : g_byte
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bytes_q[i] <= '0;
      end else if (ctrl_i.append && !ctrl_i.clear && room &&
                   fill_q == bdc_pkg::FILL_W'(i)) begin
        bytes_q[i] <= ctrl_i.data;
      end
    end
  end

  assign view_o.bytes = bytes_q;
  assign view_o.xsum  = xsum_q;

endmodule

@@ rtl/bdc_exec.sv @@
// configuration registers, command execute and register read decode
// depends on bdc_pkg

module bdc_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                fire_i,
  input  bdc_pkg::req_t       req_i,
  input  bdc_pkg::cmd_view_t  view_i,
  output bdc_pkg::result_t    res_o
);

  logic        slot_match;
  logic [2:0]  card_slot_q;
  logic [1:0]  mounted_q, protected_q;
  logic [15:0] blocks0_q, blocks1_q;

  bdc_pkg::err_e error_q, error_d;
  logic [7:0]    stat_lo_q, stat_lo_d, stat_hi_q, stat_hi_d;

  logic [7:0]  cmd, dev;
  logic        drv, mounted, prot;
  logic [15:0] blocks;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_slot_q <= '0;
      mounted_q   <= '0;
      protected_q <= '0;
      blocks0_q   <= '0;
      blocks1_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bdc_pkg::CFG_SLOT:      card_slot_q    <= cfg_data_i[2:0];
        bdc_pkg::CFG_D0_MOUNT:  mounted_q[0]   <= cfg_data_i[0];
        bdc_pkg::CFG_D1_MOUNT:  mounted_q[1]   <= cfg_data_i[0];
        bdc_pkg::CFG_D0_PROT:   protected_q[0] <= cfg_data_i[0];
        bdc_pkg::CFG_D1_PROT:   protected_q[1] <= cfg_data_i[0];
        bdc_pkg::CFG_D0_BLOCKS: blocks0_q      <= cfg_data_i;
        bdc_pkg::CFG_D1_BLOCKS: blocks1_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command fields and selected drive
  assign cmd        = view_i.bytes[bdc_pkg::BYTE_CMD];
  assign dev        = view_i.bytes[bdc_pkg::BYTE_DEV];
  assign drv        = dev[7];
  assign mounted    = mounted_q[drv];
  assign prot       = protected_q[drv];
  assign blocks     = drv ? blocks1_q : blocks0_q;
  assign slot_match = dev[6:4] == card_slot_q;

  // read decode, execute checks and result
  always_comb begin
    res_o     = '0;
    error_d   = error_q;
    stat_lo_d = stat_lo_q;
    stat_hi_d = stat_hi_q;
    if (req_i.op == bdc_pkg::OP_READ) begin
      unique case (req_i.offset)
        bdc_pkg::OFF_ERROR:   res_o.rdata = {5'b0, error_q};
        bdc_pkg::OFF_STAT_LO: res_o.rdata = stat_lo_q;
        bdc_pkg::OFF_STAT_HI: res_o.rdata = stat_hi_q;
        default:              res_o.rdata = bdc_pkg::RD_UNUSED;
      endcase
    end else if (req_i.offset == bdc_pkg::OFF_EXEC) begin
      priority if (view_i.xsum != 8'h00 ||
                   view_i.bytes[bdc_pkg::BYTE_VERSION] != bdc_pkg::CMD_VERSION) begin
        error_d = bdc_pkg::ERR_FORMAT;
      end else if (!slot_match) begin
        error_d = bdc_pkg::ERR_IO;
      end else if (!mounted) begin
        error_d = bdc_pkg::ERR_OFFLINE;
      end else begin
        unique case (cmd)
          bdc_pkg::CMD_STATUS: begin
            error_d   = bdc_pkg::ERR_OK;
            stat_lo_d = blocks[7:0];
            stat_hi_d = blocks[15:8];
          end
          bdc_pkg::CMD_READ, bdc_pkg::CMD_WRITE: begin
            stat_lo_d = '0;
            stat_hi_d = '0;
            if (cmd == bdc_pkg::CMD_WRITE && prot) begin
              error_d = bdc_pkg::ERR_PROTECT;
            end else begin
              error_d             = bdc_pkg::ERR_OK;
              res_o.xfer_valid    = 1'b1;
              res_o.xfer_is_write = cmd == bdc_pkg::CMD_WRITE;
              res_o.xfer_drive    = drv;
              res_o.xfer_block    = {view_i.bytes[bdc_pkg::BYTE_BLK_HI],
                                     view_i.bytes[bdc_pkg::BYTE_BLK_LO]};
              res_o.xfer_mem_addr = {view_i.bytes[bdc_pkg::BYTE_ADR_HI],
                                     view_i.bytes[bdc_pkg::BYTE_ADR_LO]};
            end
          end
          bdc_pkg::CMD_FORMAT: error_d = bdc_pkg::ERR_NODEV;
          default: ;
        endcase
      end
    end
  end

  // error and status registers, updated per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_q   <= bdc_pkg::ERR_OK;
      stat_lo_q <= '0;
      stat_hi_q <= '0;
    end else if (fire_i) begin
      error_q   <= error_d;
      stat_lo_q <= stat_lo_d;
      stat_hi_q <= stat_hi_d;
    end
  end

endmodule

@@ rtl/bdc_skid.sv @@
// result register with skid stage between the request and result sides
// depends on bdc_pkg

module bdc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bdc_pkg::result_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bdc_pkg::result_t  out_data_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  bdc_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic             in_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;

  // output slot refills from skid first, else from the new result
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (in_fire) begin
        out_d       = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/block_device_command_port.sv @@
// block device command port: an accepted request's result is registered in the output
// register, or in the skid while the output stalls; one request per cycle while the
// skid is empty, since each request's buffer, error and status update completes in
// the cycle it is taken. a two-entry result stage (output plus skid register) keeps
// taking requests while one result is stalled. asynchronous active-low reset clears
// buffer, checksum, error, status and configuration registers; no clearing pass.
// depends on bdc_pkg, bdc_cmdbuf, bdc_exec, bdc_skid

module block_device_command_port (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] reg_offset, [11:4] wdata, rest zero
  input  logic        s_axis_tuser,   // [0] op
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] rdata, [8] xfer_is_write, [9] xfer_drive,
                                      // [25:10] xfer_block, [41:26] xfer_mem_addr
  output logic        m_axis_tuser,   // [0] xfer_valid
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  bdc_pkg::req_t      req;
  bdc_pkg::buf_ctrl_t buf_ctrl;
  bdc_pkg::cmd_view_t view;
  bdc_pkg::result_t   res, res_out;
  logic               fire;

  assign cfg_ready_o = 1'b1;

  // request unpack
  assign req.op     = bdc_pkg::op_e'(s_axis_tuser);
  assign req.offset = s_axis_tdata[3:0];
  assign req.wdata  = s_axis_tdata[11:4];
  assign fire       = s_axis_tvalid && s_axis_tready;

  // buffer control: clear on clear and execute writes, append on data writes
  assign buf_ctrl.clear  = fire && req.op == bdc_pkg::OP_WRITE &&
                           (req.offset == bdc_pkg::OFF_CLEAR ||
                            req.offset == bdc_pkg::OFF_EXEC);
  assign buf_ctrl.append = fire && req.op == bdc_pkg::OP_WRITE &&
                           req.offset == bdc_pkg::OFF_APPEND;
  assign buf_ctrl.data   = req.wdata;

  bdc_cmdbuf u_cmdbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (buf_ctrl),
    .view_o (view)
  );

  bdc_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .req_i       (req),
    .view_i      (view),
    .res_o       (res)
  );

  bdc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  // result pack
  assign m_axis_tdata = {6'b0, res_out.xfer_mem_addr, res_out.xfer_block,
                         res_out.xfer_drive, res_out.xfer_is_write, res_out.rdata};
  assign m_axis_tuser = res_out.xfer_valid;

endmodule

@@ rtl/bdc_checker.sv @@
// port-level checks for the block device command port, bound to the top level
// depends on block_device_command_port

module bdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // request side only stalls when a result is waiting
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("request side stalled with empty result register");

  // an accepted request is followed by a valid result in the next cycle, its own or an earlier stalled one
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request left no result");

  // no transfer request means zero transfer fields
  a_noxfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[41:8] == 34'b0)
    else $error("transfer fields set without transfer request");

  // a transfer request comes from an execute write, so read data is zero
  a_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("read data on transfer request");

endmodule

bind block_device_command_port bdc_checker u_bdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
